/* sv/dvrt_pkg.sv */
// Shared types and constants of the distance-vector route table.
package dvrt_pkg;

    // Operation codes of a command transfer
    localparam logic [1:0] OP_BEACON = 2'd0;
    localparam logic [1:0] OP_SWEEP  = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT = 1'b1;

    localparam logic [3:0] SELF_ID_RESET     = 4'd1;
    localparam logic [7:0] STALE_LIMIT_RESET = 8'd10;

    // Costs
    localparam logic [7:0] COST_UNREACH = 8'd255;
    localparam logic [8:0] COST_LIMIT   = 9'd254;

    // RSSI thresholds (dBm) and link penalties
    localparam logic signed [7:0] RSSI_STRONG = -8'sd55;
    localparam logic signed [7:0] RSSI_FAIR   = -8'sd70;
    localparam logic signed [7:0] RSSI_WEAK   = -8'sd85;
    localparam logic [7:0] PEN_STRONG = 8'd1;
    localparam logic [7:0] PEN_FAIR   = 8'd4;
    localparam logic [7:0] PEN_WEAK   = 8'd15;
    localparam logic [7:0] PEN_POOR   = 8'd50;

    typedef struct packed {
        logic [1:0]        operation;
        logic [3:0]        sender_id;
        logic signed [7:0] rssi;
        logic [63:0]       advertised_costs;
        logic [31:0]       now_seconds;
        logic [2:0]        dest_index;
    } t_cmd;

    typedef struct packed {
        logic [7:0] route_cost;
        logic [3:0] route_hop;
        logic       reachable;
        logic [3:0] expired_count;
    } t_result;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [7:0]  cost;
        logic [3:0]  hop;
        logic [31:0] seen_s;
    } t_entry;

endpackage

/* sv/distance_vector_route_table.sv */
// Top level of the distance-vector route table: sequencer around one entry RAM.
//
//  channel   direction  handshake                 payload
//  command   in         i_start && !o_busy        i_cmd (t_cmd)
//  result    out        o_done, one cycle         o_result (t_result)
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_wdata
//
// Cycles: every entry goes through the single RAM read port one per cycle.
// A valid beacon goes through direct write, pass, drain, dest read and output
// load, a sweep through the same steps without direct write, a query or ignored
// beacon through dest read and output load only. o_done is high in the first cycle
// with o_busy low; a new command may be transferred in that cycle. Reset is
// synchronous; the RAM is not cleared, per-entry valid bits make unwritten entries
// read as their reset values. The receiver cannot stall: each result is shown once for one cycle.
module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int NODE_COUNT = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_cmd                  i_cmd,
    output logic                  o_done,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int EW = $bits(t_entry);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIRECT = 6'b000010,  // write the sender's direct entry
        S_PASS   = 6'b000100,  // read entry idx, update entry idx-1
        S_LAST   = 6'b001000,  // update the last entry
        S_DREAD  = 6'b010000,  // read the reported entry
        S_DOUT   = 6'b100000   // load the result register
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [3:0] r_self;
    logic [7:0] r_limit;

    // latched command
    logic        r_is_beacon;
    logic [3:0]  r_nb;
    logic [7:0]  r_pen;
    logic [63:0] r_costs;
    logic [31:0] r_now;
    logic [2:0]  r_dest;

    logic [AW-1:0]         r_idx;
    logic [3:0]            r_count;
    logic                  r_pend;     // RAM output holds an entry to update
    logic [AW-1:0]         r_rd_idx;
    logic                  r_rd_vld;
    logic [NODE_COUNT-1:0] r_valid;

    logic    r_done;
    t_result r_result, n_result;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_q;

    logic       accept;
    logic       nb_ok;
    logic [7:0] pen;
    t_entry     rd_entry;
    t_entry     new_entry;
    logic       upd;
    logic       cnt_inc;
    logic       is_self;
    logic [7:0] adv;
    logic [8:0] sum;
    logic [7:0] prop;
    logic       dest_ok;

    function automatic t_entry rst_entry(input logic [AW-1:0] idx);
        t_entry e;
        e.cost   = (idx == '0) ? 8'd0 : COST_UNREACH;
        e.hop    = (idx == '0) ? SELF_ID_RESET : 4'd0;
        e.seen_s = 32'd0;
        return e;
    endfunction

    dvrt_ram #(
        .WIDTH (EW),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE);
    assign nb_ok  = (i_cmd.sender_id != 4'd0) &&
                    ({1'b0, i_cmd.sender_id} <= 5'(NODE_COUNT));

    // RSSI to link penalty
    always_comb begin
        priority if (i_cmd.rssi >= RSSI_STRONG) begin
            pen = PEN_STRONG;
        end else if (i_cmd.rssi >= RSSI_FAIR) begin
            pen = PEN_FAIR;
        end else if (i_cmd.rssi >= RSSI_WEAK) begin
            pen = PEN_WEAK;
        end else begin
            pen = PEN_POOR;
        end
    end

    // never-written entries read as reset values
    assign rd_entry = r_rd_vld ? t_entry'(ram_q) : rst_entry(r_rd_idx);

    // per-entry relax / age step on the entry at the RAM output
    always_comb begin
        upd       = 1'b0;
        cnt_inc   = 1'b0;
        new_entry = rd_entry;
        is_self   = (4'(r_rd_idx) + 4'd1 == r_self);
        adv       = r_costs[{r_rd_idx, 3'b000} +: 8];
        sum       = {1'b0, adv} + {1'b0, r_pen};
        prop      = (sum > COST_LIMIT) ? COST_UNREACH : sum[7:0];
        if (r_pend && !is_self) begin
            if (r_is_beacon) begin
                if (adv != COST_UNREACH) begin
                    if (prop < rd_entry.cost) begin
                        upd              = 1'b1;
                        new_entry.cost   = prop;
                        new_entry.hop    = r_nb;
                        new_entry.seen_s = r_now;
                    end else if (rd_entry.hop == r_nb) begin
                        upd              = 1'b1;
                        new_entry.cost   = prop;
                        new_entry.seen_s = r_now;
                    end
                end
            end else begin
                if ((rd_entry.cost != COST_UNREACH) &&
                    ((r_now - rd_entry.seen_s) > {24'd0, r_limit})) begin
                    upd            = 1'b1;
                    cnt_inc        = 1'b1;
                    new_entry.cost = COST_UNREACH;
                end
            end
        end
    end

    // RAM access
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_rd_idx;
        ram_wdata = new_entry;
        ram_raddr = r_idx;
        unique case (r_state)
            S_DIRECT: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_nb - 4'd1);
                ram_wdata = '{cost: r_pen, hop: r_nb, seen_s: r_now};
            end
            S_PASS, S_LAST: begin
                ram_we = upd;
            end
            S_DREAD: begin
                ram_raddr = AW'(r_dest);
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (i_cmd.operation == OP_BEACON && nb_ok) begin
                        n_state = S_DIRECT;
                    end else if (i_cmd.operation == OP_SWEEP) begin
                        n_state = S_PASS;
                    end else begin
                        n_state = S_DREAD;  // query, unused code, ignored beacon
                    end
                end
            end
            S_DIRECT: n_state = S_PASS;
            S_PASS:   n_state = (r_idx == AW'(NODE_COUNT - 1)) ? S_LAST : S_PASS;
            S_LAST:   n_state = S_DREAD;
            S_DREAD:  n_state = S_DOUT;
            S_DOUT:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign dest_ok = ({1'b0, r_dest} < 4'(NODE_COUNT));

    always_comb begin
        n_result.route_cost    = dest_ok ? rd_entry.cost : COST_UNREACH;
        n_result.route_hop     = dest_ok ? rd_entry.hop : 4'd0;
        n_result.reachable     = (n_result.route_cost != COST_UNREACH);
        n_result.expired_count = r_count;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_self  <= SELF_ID_RESET;
            r_limit <= STALE_LIMIT_RESET;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_valid <= '0;
            r_idx   <= '0;
            r_count <= 4'd0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_PASS);
            r_done  <= (r_state == S_DOUT);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SELF_ID:     r_self  <= i_cfg_wdata[3:0];
                    CFG_STALE_LIMIT: r_limit <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (accept) begin
                r_idx   <= '0;
                r_count <= 4'd0;
            end else begin
                if (r_state == S_PASS) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (cnt_inc) begin
                    r_count <= r_count + 4'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_beacon <= (i_cmd.operation == OP_BEACON);
            r_nb        <= i_cmd.sender_id;
            r_pen       <= pen;
            r_costs     <= i_cmd.advertised_costs;
            r_now       <= i_cmd.now_seconds;
            r_dest      <= i_cmd.dest_index;
        end
        r_rd_idx <= ram_raddr;
        r_rd_vld <= r_valid[ram_raddr];
        if (r_state == S_DOUT) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_done_after_dout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_DOUT))
        else $error("result strobe without output load");

    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_DIRECT || r_state == S_PASS || r_state == S_LAST))
        else $error("table write outside an update phase");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS && ram_we) |-> (ram_waddr != ram_raddr))
        else $error("read and write of the same entry in one cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 4'(NODE_COUNT))
        else $error("expired count beyond table size");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("command transfer did not start the sequencer");
`endif

endmodule

/* sv/dvrt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
